FILE: rtl/u8to16_pkg.sv
// ----------------------------------------------------------------------------
// u8to16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8to16_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned CP_W       = 21;
	localparam int unsigned UNIT_W     = 16;
	localparam int unsigned BYTE_W     = 8;

	// byte class limits
	localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
	localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
	localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;

	// payload masks
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

	// surrogate forming
	localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h010000;
	localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;

	// one decoded code point waiting to be written out
	typedef struct packed {
		logic            pair;
		logic [CP_W-1:0] cp;
	} job_t;

endpackage

`default_nettype wire

FILE: rtl/u8to16_front.sv
// ----------------------------------------------------------------------------
// u8to16_front
// Byte classifier: assembles code points and posts finished ones as jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module u8to16_front (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                byte_valid,
	input  wire  [u8to16_pkg::BYTE_W-1:0]      byte_data,
	input  wire                                job_full,
	output logic                               byte_ready,
	output logic                               job_push,
	output u8to16_pkg::job_t                   job
);
	import u8to16_pkg::*;

	logic [CP_W-1:0] pp_q;
	logic [1:0]      pend_q;
	logic [CP_W-1:0] pp_nx;
	logic [1:0]      pend_nx;
	logic            take;

	assign byte_ready = !job_full;
	assign take       = byte_valid && !job_full;

	always_comb begin
		pp_nx   = pp_q;
		pend_nx = pend_q;
		priority if (byte_data <= ASCII_MAX) begin
			pp_nx   = {{(CP_W-BYTE_W){1'b0}}, byte_data};
			pend_nx = 2'd0;
		end else if (byte_data <= CONT_MAX) begin
			if (pend_q != 2'd0) begin
				pp_nx   = {pp_q[CP_W-7:0], byte_data[5:0] & CONT_MASK[5:0]};
				pend_nx = pend_q - 2'd1;
			end
		end else if (byte_data <= LEAD2_MAX) begin
			pp_nx   = {{(CP_W-BYTE_W){1'b0}}, byte_data & LEAD2_MASK};
			pend_nx = 2'd1;
		end else if (byte_data <= LEAD3_MAX) begin
			pp_nx   = {{(CP_W-BYTE_W){1'b0}}, byte_data & LEAD3_MASK};
			pend_nx = 2'd2;
		end else begin
			pp_nx   = {{(CP_W-BYTE_W){1'b0}}, byte_data & LEAD4_MASK};
			pend_nx = 2'd3;
		end
	end

	assign job_push = take && (pend_nx == 2'd0);
	assign job.cp   = pp_nx;
	assign job.pair = |pp_nx[CP_W-1:UNIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q   <= '0;
			pend_q <= 2'd0;
		end else if (take) begin
			// a finished sequence leaves an empty accumulator
			pp_q   <= (pend_nx == 2'd0) ? '0 : pp_nx;
			pend_q <= pend_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/u8to16_fifo.sv
// ----------------------------------------------------------------------------
// u8to16_fifo
// Short job queue between the classifier and the unit writer.
// ----------------------------------------------------------------------------
`default_nettype none

module u8to16_fifo #(
	parameter int unsigned Depth = u8to16_pkg::FIFO_DEPTH
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  u8to16_pkg::job_t       push_job,
	input  wire                    pop,
	output logic                   full,
	output logic                   head_valid,
	output u8to16_pkg::job_t       head_job
);
	import u8to16_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full       = (cnt_q == CntFull);
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_wr      = push && !full;
	assign do_rd      = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/u8to16_back.sv
// ----------------------------------------------------------------------------
// u8to16_back
// Unit writer: turns jobs into one code unit or a surrogate pair.
// ----------------------------------------------------------------------------
`default_nettype none

module u8to16_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                head_valid,
	input  u8to16_pkg::job_t                   head_job,
	input  wire                                unit_ready,
	output logic                               pop,
	output logic                               unit_valid,
	output logic [u8to16_pkg::UNIT_W-1:0]      unit_data,
	output logic                               unit_last
);
	import u8to16_pkg::*;

	logic              valid_q;
	logic              half_q;
	logic [UNIT_W-1:0] unit_q;
	logic              last_q;
	logic              load;
	logic              first_of_pair;
	logic [CP_W-1:0]   v;
	logic [UNIT_W-1:0] hi;
	logic [UNIT_W-1:0] lo;

	assign load          = head_valid && (!valid_q || unit_ready);
	assign first_of_pair = head_job.pair && !half_q;
	assign pop           = load && !first_of_pair;

	assign v  = head_job.cp - SUPP_BASE;
	assign hi = SURR_HI_BASE + {{(UNIT_W-(CP_W-10)){1'b0}}, v[CP_W-1:10]};
	assign lo = SURR_LO_BASE + {{(UNIT_W-10){1'b0}}, v[9:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			half_q  <= first_of_pair;
		end else if (unit_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= !first_of_pair;
			if (!head_job.pair) begin
				unit_q <= head_job.cp[UNIT_W-1:0];
			end else if (first_of_pair) begin
				unit_q <= hi;
			end else begin
				unit_q <= lo;
			end
		end
	end

	assign unit_valid = valid_q;
	assign unit_data  = unit_q;
	assign unit_last  = last_q;

endmodule

`default_nettype wire

FILE: rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Stream converter from UTF-8 bytes to UTF-16 code units.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one UTF-8 byte per transfer in tdata[7:0].
//   Master stream m_axis carries one UTF-16 code unit per transfer in
//   tdata[15:0]; tlast marks the final unit caused by one input byte.
//   A byte that completes a code point up to U+FFFF gives one unit, one
//   above gives a surrogate pair (high half first), other bytes give none.
//   A stray continuation byte gives U+0000; a lead byte drops an unfinished
//   sequence.
// Timing:
//   One byte is taken every cycle while the job queue has room. A byte's
//   first unit passes the job queue and the output register; the second
//   half of a pair follows. The writer produces one unit per cycle while
//   m_axis is ready; a pair holds the queue head until both halves load.
// Reset and stalls:
//   arst_n clears the code point accumulator, the queue and the output
//   register. When m_axis stalls, the output unit holds, the queue fills up
//   to FifoDepth jobs, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder #(
	parameter int unsigned FifoDepth = u8to16_pkg::FIFO_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] code_unit
	output logic        m_axis_tlast    // last_of_item
);
	import u8to16_pkg::*;

	logic job_push;
	job_t job;
	logic job_full;
	logic head_valid;
	job_t head_job;
	logic pop;

	// classify bytes and assemble code points
	u8to16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_data  (s_axis_tdata),
		.job_full   (job_full),
		.byte_ready (s_axis_tready),
		.job_push   (job_push),
		.job        (job)
	);

	// hold finished code points so either side can stall alone
	u8to16_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.pop        (pop),
		.full       (job_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// write out units, splitting supplementary code points into pairs
	u8to16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.unit_ready (m_axis_tready),
		.pop        (pop),
		.unit_valid (m_axis_tvalid),
		.unit_data  (m_axis_tdata),
		.unit_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire
